// ----- design/apid_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the arm position PID regulator.
// Holds the fixed-point widths, the microcode control word and the status fields.
// Used by apid_seq, apid_dp and arm_position_pid_regulator_top; no dependencies.
package apid_pkg;

    localparam int SENSOR_BITS        = 12;
    localparam int GAIN_FRAC_BITS     = 24;
    localparam int INTEGRAL_FRAC_BITS = 8;

    localparam int ERR_W      = SENSOR_BITS + 2;
    localparam int MAG_W      = ERR_W - 1;
    localparam int DER_W      = ERR_W + 1;
    localparam int SHMAG_W    = MAG_W + INTEGRAL_FRAC_BITS;
    localparam int RECIP_SH   = SHMAG_W + 4;
    localparam int RECIP_W    = RECIP_SH - 3;
    localparam int QUO_W      = SHMAG_W - 3;
    localparam int INT_W      = 32;
    localparam int DRV_W      = 8;
    localparam int SCALE_W    = 9;
    localparam int SCALE_FRAC = 8;
    localparam int DEADBAND_W = 8;
    localparam int DRIVE_LIMIT = 127;
    localparam int INTEGRAL_DIVISOR = 10;

    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SH) + 64'(INTEGRAL_DIVISOR - 1)) / 64'(INTEGRAL_DIVISOR);

    localparam int MUL_A_W = (SHMAG_W + 1 > INT_W + 1) ? SHMAG_W + 1 : INT_W + 1;
    localparam int MUL_B_W = (GAIN_FRAC_BITS + 1 > RECIP_W + 1) ?
                             GAIN_FRAC_BITS + 1 : RECIP_W + 1;
    localparam int P_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = P_W + INTEGRAL_FRAC_BITS + 2;
    localparam int TOT_SH  = GAIN_FRAC_BITS + INTEGRAL_FRAC_BITS;

    localparam int S_TDATA_W  = ((2 * SENSOR_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DRV_W + ERR_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = (GAIN_FRAC_BITS > SENSOR_BITS) ? GAIN_FRAC_BITS : SENSOR_BITS;
    localparam int STEP_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_POSITION_OFFSET     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROPORTIONAL   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEGRAL       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIVATIVE     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_DEADBAND   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MANUAL_DOWN   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MANUAL_UP     = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_PRESET_UP     = CFG_IDX_W'(7);

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        A_MAG, A_ERR, A_INT, A_DER, A_DRV
    } mul_a_t;

    typedef enum logic [2:0] {
        B_RECIP, B_KP, B_KI, B_KD, B_SCALE
    } mul_b_t;

    typedef enum logic [1:0] {
        ACC_NOP, ACC_LOAD_SH, ACC_ADD, ACC_ADD_SH
    } acc_op_t;

    typedef enum logic [1:0] {
        DRV_NOP, DRV_TOTAL, DRV_SCALED
    } drv_op_t;

    typedef enum logic {
        JMP_NONE, JMP_BYPASS
    } jmp_t;

    typedef struct packed {
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        acc_op_t acc_op;
        drv_op_t drv_op;
        logic    int_upd;
        logic    der_upd;
        jmp_t    jmp;
        step_t   target;
        logic    done;
    } ctrl_t;

    typedef struct packed {
        logic bypass;
    } stat_t;

endpackage

// ----- design/apid_seq.sv -----
`timescale 1ns / 1ps
// Microcode sequencer of the arm position PID regulator.
// Holds the program ROM, the step counter and the input and output handshake control.
// Depends on apid_pkg.
module apid_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            in_load,
    input  logic            out_free,
    output logic            out_load,
    input  apid_pkg::stat_t stat,
    output apid_pkg::ctrl_t ctrl
);
    import apid_pkg::*;

    localparam step_t ST_RECIP  = STEP_W'(0);
    localparam step_t ST_INTEG  = STEP_W'(1);
    localparam step_t ST_KP     = STEP_W'(2);
    localparam step_t ST_KI     = STEP_W'(3);
    localparam step_t ST_KD     = STEP_W'(4);
    localparam step_t ST_CLAMP  = STEP_W'(5);
    localparam step_t ST_SCALE  = STEP_W'(6);
    localparam step_t ST_RESULT = STEP_W'(7);
    localparam step_t ST_DONE   = STEP_W'(8);

    localparam ctrl_t CTRL_IDLE = '{
        mul_a: A_MAG, mul_b: B_RECIP, acc_op: ACC_NOP, drv_op: DRV_NOP,
        int_upd: 1'b0, der_upd: 1'b0, jmp: JMP_NONE, target: ST_RECIP, done: 1'b0
    };

    function automatic ctrl_t rom(input step_t step);
        ctrl_t cw;
        cw = CTRL_IDLE;
        unique case (step)
            ST_RECIP: begin
                cw.mul_a   = A_MAG;
                cw.mul_b   = B_RECIP;
                cw.der_upd = 1'b1;
            end
            ST_INTEG: begin
                cw.mul_a   = A_ERR;
                cw.mul_b   = B_KP;
                cw.int_upd = 1'b1;
            end
            ST_KP: begin
                cw.mul_a  = A_INT;
                cw.mul_b  = B_KI;
                cw.acc_op = ACC_LOAD_SH;
            end
            ST_KI: begin
                cw.mul_a  = A_DER;
                cw.mul_b  = B_KD;
                cw.acc_op = ACC_ADD;
            end
            ST_KD: begin
                cw.acc_op = ACC_ADD_SH;
            end
            ST_CLAMP: begin
                cw.drv_op = DRV_TOTAL;
                cw.jmp    = JMP_BYPASS;
                cw.target = ST_DONE;
            end
            ST_SCALE: begin
                cw.mul_a = A_DRV;
                cw.mul_b = B_SCALE;
            end
            ST_RESULT: begin
                cw.drv_op = DRV_SCALED;
            end
            ST_DONE: begin
                cw.done = 1'b1;
            end
            default: cw = CTRL_IDLE;
        endcase
        return cw;
    endfunction

    logic  busy_reg, busy_next;
    step_t step_reg, step_next;
    ctrl_t cw;
    logic  taken;

    assign cw       = rom(step_reg);
    assign in_ready = ~busy_reg;
    assign in_load  = in_valid & ~busy_reg;
    assign out_load = busy_reg & cw.done & out_free;
    assign ctrl     = busy_reg ? cw : CTRL_IDLE;
    assign taken    = (cw.jmp == JMP_BYPASS) & stat.bypass;

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (in_load) begin
            busy_next = 1'b1;
            step_next = ST_RECIP;
        end else if (busy_reg) begin
            if (cw.done) begin
                if (out_free) begin
                    busy_next = 1'b0;
                end
            end else if (taken) begin
                step_next = cw.target;
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= ST_RECIP;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

endmodule

// ----- design/apid_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the arm position PID regulator: error, integral, derivative,
// one shared multiplier, the accumulator and the drive clamp and scaling.
// Depends on apid_pkg; driven by the control word from apid_seq.
module apid_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_load,
    input  logic [apid_pkg::SENSOR_BITS-1:0]     sensor_sample,
    input  logic [apid_pkg::SENSOR_BITS-1:0]     target,
    input  logic                                 manual_mode,
    input  logic [apid_pkg::SENSOR_BITS-1:0]     position_offset,
    input  logic [apid_pkg::GAIN_FRAC_BITS-1:0]  gain_proportional,
    input  logic [apid_pkg::GAIN_FRAC_BITS-1:0]  gain_integral,
    input  logic [apid_pkg::GAIN_FRAC_BITS-1:0]  gain_derivative,
    input  logic [apid_pkg::DEADBAND_W-1:0]      integral_deadband,
    input  logic [apid_pkg::SCALE_W-1:0]         scale_manual_down,
    input  logic [apid_pkg::SCALE_W-1:0]         scale_manual_up,
    input  logic [apid_pkg::SCALE_W-1:0]         scale_preset_up,
    input  apid_pkg::ctrl_t                      ctrl,
    output apid_pkg::stat_t                      stat,
    output logic signed [apid_pkg::DRV_W-1:0]    drive,
    output logic signed [apid_pkg::ERR_W-1:0]    position_error
);
    import apid_pkg::*;

    localparam logic signed [ACC_W-1:0]   LIM_P   = ACC_W'(DRIVE_LIMIT);
    localparam logic signed [ACC_W-1:0]   LIM_N   = -LIM_P;
    localparam logic signed [INT_W+1:0]   INT_MAX = (INT_W+2)'((64'd1 << (INT_W - 1)) - 64'd1);
    localparam logic signed [INT_W+1:0]   INT_MIN = -INT_MAX - (INT_W+2)'(1);
    localparam logic [RECIP_W-1:0]        RECIP_C = RECIP_W'(RECIP);

    function automatic logic signed [DRV_W-1:0] clamp_drv(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        if (v > LIM_P) begin
            c = LIM_P;
        end else if (v < LIM_N) begin
            c = LIM_N;
        end else begin
            c = v;
        end
        return DRV_W'(c);
    endfunction

    logic signed [ERR_W-1:0]   err_reg;
    logic signed [ERR_W-1:0]   prev_reg;
    logic signed [DER_W-1:0]   der_reg;
    logic signed [INT_W-1:0]   int_reg, int_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [P_W-1:0]     prod_reg;
    logic signed [DRV_W-1:0]   drv_reg, drv_next;
    logic                      manual_reg;

    logic signed [ERR_W-1:0]   err_in;
    logic                      err_neg;
    logic [MAG_W-1:0]          mag;
    logic [QUO_W-1:0]          quo;
    logic signed [QUO_W:0]     inc;
    logic signed [INT_W+1:0]   int_sum, int_sat;
    logic                      in_band;
    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic [SCALE_W-1:0]        scale_sel;
    logic signed [ACC_W-1:0]   tot_fl, tot_q, sc_fl, sc_q;
    logic                      tot_adj, sc_adj;
    logic signed [DRV_W-1:0]   drv_total, drv_scaled;

    assign err_in = ERR_W'({2'b00, target}) - ERR_W'({2'b00, sensor_sample})
                  + ERR_W'({2'b00, position_offset});

    assign err_neg = err_reg[ERR_W-1];
    assign mag     = MAG_W'(err_neg ? -err_reg : err_reg);
    assign quo     = prod_reg[RECIP_SH +: QUO_W];
    assign inc     = err_neg ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
    assign int_sum = (INT_W+2)'(int_reg) + (INT_W+2)'(inc);
    assign in_band = mag < MAG_W'(integral_deadband);

    always_comb begin
        if (int_sum > INT_MAX) begin
            int_sat = INT_MAX;
        end else if (int_sum < INT_MIN) begin
            int_sat = INT_MIN;
        end else begin
            int_sat = int_sum;
        end
        int_next = int_reg;
        if (ctrl.int_upd) begin
            int_next = in_band ? '0 : INT_W'(int_sat);
        end
    end

    always_comb begin
        if (manual_reg && drv_reg[DRV_W-1]) begin
            scale_sel = scale_manual_down;
        end else if (manual_reg) begin
            scale_sel = scale_manual_up;
        end else begin
            scale_sel = scale_preset_up;
        end
    end

    always_comb begin
        unique case (ctrl.mul_a)
            A_MAG:   op_a = MUL_A_W'(signed'({1'b0, mag, {INTEGRAL_FRAC_BITS{1'b0}}}));
            A_ERR:   op_a = MUL_A_W'(err_reg);
            A_INT:   op_a = MUL_A_W'(int_reg);
            A_DER:   op_a = MUL_A_W'(der_reg);
            A_DRV:   op_a = MUL_A_W'(drv_reg);
            default: op_a = '0;
        endcase
        unique case (ctrl.mul_b)
            B_RECIP: op_b = MUL_B_W'(signed'({1'b0, RECIP_C}));
            B_KP:    op_b = MUL_B_W'(signed'({1'b0, gain_proportional}));
            B_KI:    op_b = MUL_B_W'(signed'({1'b0, gain_integral}));
            B_KD:    op_b = MUL_B_W'(signed'({1'b0, gain_derivative}));
            B_SCALE: op_b = MUL_B_W'(signed'({1'b0, scale_sel}));
            default: op_b = '0;
        endcase
    end

    always_comb begin
        unique case (ctrl.acc_op)
            ACC_LOAD_SH: acc_next = ACC_W'(prod_reg) <<< INTEGRAL_FRAC_BITS;
            ACC_ADD:     acc_next = acc_reg + ACC_W'(prod_reg);
            ACC_ADD_SH:  acc_next = acc_reg + (ACC_W'(prod_reg) <<< INTEGRAL_FRAC_BITS);
            default:     acc_next = acc_reg;
        endcase
    end

    always_comb begin
        tot_fl     = acc_reg >>> TOT_SH;
        tot_adj    = acc_reg[ACC_W-1] & (|acc_reg[TOT_SH-1:0]);
        tot_q      = tot_fl + signed'(ACC_W'(tot_adj));
        drv_total  = clamp_drv(tot_q);
        sc_fl      = ACC_W'(prod_reg >>> SCALE_FRAC);
        sc_adj     = prod_reg[P_W-1] & (|prod_reg[SCALE_FRAC-1:0]);
        sc_q       = sc_fl + signed'(ACC_W'(sc_adj));
        drv_scaled = clamp_drv(sc_q);
    end

    always_comb begin
        unique case (ctrl.drv_op)
            DRV_TOTAL:  drv_next = drv_total;
            DRV_SCALED: drv_next = drv_scaled;
            default:    drv_next = drv_reg;
        endcase
    end

    assign stat.bypass = (drv_total == '0) | (~manual_reg & drv_total[DRV_W-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_reg  <= '0;
            prev_reg <= '0;
        end else begin
            int_reg <= int_next;
            if (ctrl.der_upd) begin
                prev_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            err_reg    <= err_in;
            manual_reg <= manual_mode;
        end
        if (ctrl.der_upd) begin
            der_reg <= DER_W'(err_reg) - DER_W'(prev_reg);
        end
        prod_reg <= P_W'(op_a * op_b);
        acc_reg  <= acc_next;
        drv_reg  <= drv_next;
    end

    assign drive          = drv_reg;
    assign position_error = err_reg;

endmodule

// ----- design/arm_position_pid_regulator_top.sv -----
`timescale 1ns / 1ps
// Top level of the arm position PID regulator: configuration registers,
// result register and the sequencer and datapath instances.
// Depends on apid_pkg, apid_seq and apid_dp.

// A request is taken on the input stream only while the regulator is idle; its result is
// loaded into the output register once the microprogram reaches its done step and the output
// register is free, and sooner when the clamped drive is zero or is negative in preset mode,
// because the microprogram then skips the scaling steps. The microprogram runs the reciprocal
// divide, the three gain products and the mode scaling one after another through a single
// shared multiplier. The next request is accepted in the cycle after the result is loaded into
// the output register, even if that result has not yet been taken. Configuration writes are
// always accepted and must be issued only while no request is in flight; an index beyond the
// register list is ignored.
module arm_position_pid_regulator_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: sensor_sample, target
    input  logic [apid_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: manual_mode
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: drive, position_error, zero fill
    output logic [apid_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [apid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [apid_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import apid_pkg::*;

    logic [SENSOR_BITS-1:0]    offset_reg;
    logic [GAIN_FRAC_BITS-1:0] kp_reg, ki_reg, kd_reg;
    logic [DEADBAND_W-1:0]     deadband_reg;
    logic [SCALE_W-1:0]        sc_down_reg, sc_up_reg, sc_preset_reg;

    logic                      m_valid_reg, m_valid_next;
    logic signed [DRV_W-1:0]   m_drive_reg;
    logic signed [ERR_W-1:0]   m_err_reg;

    logic                      in_load, out_load, out_free;
    ctrl_t                     ctrl;
    stat_t                     stat;
    logic signed [DRV_W-1:0]   drive;
    logic signed [ERR_W-1:0]   position_error;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg    <= '0;
            kp_reg        <= GAIN_FRAC_BITS'(1174405);
            ki_reg        <= GAIN_FRAC_BITS'(419);
            kd_reg        <= GAIN_FRAC_BITS'(5033);
            deadband_reg  <= DEADBAND_W'(5);
            sc_down_reg   <= SCALE_W'(205);
            sc_up_reg     <= SCALE_W'(154);
            sc_preset_reg <= SCALE_W'(128);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_POSITION_OFFSET:   offset_reg    <= cfg_data[SENSOR_BITS-1:0];
                REG_GAIN_PROPORTIONAL: kp_reg        <= cfg_data[GAIN_FRAC_BITS-1:0];
                REG_GAIN_INTEGRAL:     ki_reg        <= cfg_data[GAIN_FRAC_BITS-1:0];
                REG_GAIN_DERIVATIVE:   kd_reg        <= cfg_data[GAIN_FRAC_BITS-1:0];
                REG_INTEGRAL_DEADBAND: deadband_reg  <= cfg_data[DEADBAND_W-1:0];
                REG_SCALE_MANUAL_DOWN: sc_down_reg   <= cfg_data[SCALE_W-1:0];
                REG_SCALE_MANUAL_UP:   sc_up_reg     <= cfg_data[SCALE_W-1:0];
                REG_SCALE_PRESET_UP:   sc_preset_reg <= cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    apid_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_load  (in_load),
        .out_free (out_free),
        .out_load (out_load),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    apid_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_load           (in_load),
        .sensor_sample     (s_tdata[SENSOR_BITS-1:0]),
        .target            (s_tdata[2*SENSOR_BITS-1:SENSOR_BITS]),
        .manual_mode       (s_tuser),
        .position_offset   (offset_reg),
        .gain_proportional (kp_reg),
        .gain_integral     (ki_reg),
        .gain_derivative   (kd_reg),
        .integral_deadband (deadband_reg),
        .scale_manual_down (sc_down_reg),
        .scale_manual_up   (sc_up_reg),
        .scale_preset_up   (sc_preset_reg),
        .ctrl              (ctrl),
        .stat              (stat),
        .drive             (drive),
        .position_error    (position_error)
    );

    assign out_free = ~m_valid_reg | m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_drive_reg <= drive;
            m_err_reg   <= position_error;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_err_reg, m_drive_reg});

endmodule

// ----- dv/arm_position_pid_regulator_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for arm_position_pid_regulator_top: a directed set of ticks,
// random phases over several register settings and idle patterns, and a short integral run.
// Depends on apid_pkg and the regulator RTL; every result is checked against a local predictor.
module arm_position_pid_regulator_top_tb;
    import apid_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_TICKS = 48;
    localparam int REG_COUNT = 8;
    localparam int REG_INDEX_MAX = (1 << CFG_IDX_W) - 1;
    localparam longint INTEG_MAX = 64'sd2147483647;
    localparam longint INTEG_MIN = -64'sd2147483648;
    localparam longint SUM_DIVISOR = 64'sd4294967296;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [SENSOR_BITS-1:0] sample;
        logic [SENSOR_BITS-1:0] target;
        logic                   manual;
    } tick_req_t;

    typedef struct packed {
        logic signed [DRV_W-1:0] drive;
        logic signed [ERR_W-1:0] position_error;
    } arm_command_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata = '0;
    logic                    s_tuser = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    tick_req_t     tick_requests[$];
    arm_command_t  predicted_commands[$];
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_stall_pct = 0;
    int            mismatch_count = 0;
    int            quiet_cycles = 0;

    longint cfg_offset = 0;
    longint cfg_kp = 1174405;
    longint cfg_ki = 419;
    longint cfg_kd = 5033;
    longint cfg_deadband = 5;
    longint cfg_manual_down = 205;
    longint cfg_manual_up = 154;
    longint cfg_preset_up = 128;
    longint integ_q8 = 0;
    longint last_error = 0;

    arm_position_pid_regulator_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic arm_command_t regulate_tick(input longint sample, input longint target,
                                                   input logic manual);
        longint err, mag, deriv, total, drv;
        arm_command_t cmd;
        err = target - (sample - cfg_offset);
        integ_q8 = clip(integ_q8 + (err * 256) / 10, INTEG_MIN, INTEG_MAX);
        mag = (err < 0) ? -err : err;
        if (mag < cfg_deadband) begin
            integ_q8 = 0;
        end
        deriv = err - last_error;
        last_error = err;
        total = cfg_kp * err * 256 + cfg_ki * integ_q8 + cfg_kd * deriv * 256;
        drv = clip(total / SUM_DIVISOR, -DRIVE_LIMIT, DRIVE_LIMIT);
        if (manual && drv < 0) begin
            drv = (drv * cfg_manual_down) / 256;
        end else if (manual && drv > 0) begin
            drv = (drv * cfg_manual_up) / 256;
        end else if (drv > 0) begin
            drv = (drv * cfg_preset_up) / 256;
        end
        drv = clip(drv, -DRIVE_LIMIT, DRIVE_LIMIT);
        cmd.drive = drv[DRV_W-1:0];
        cmd.position_error = err[ERR_W-1:0];
        return cmd;
    endfunction

    function automatic tick_req_t random_request();
        tick_req_t r;
        int t;
        r.manual = 1'($urandom_range(1));
        r.sample = SENSOR_BITS'($urandom);
        r.target = SENSOR_BITS'($urandom);
        if ($urandom_range(3) != 0) begin
            t = int'(r.sample) - int'(cfg_offset) + int'($urandom_range(80)) - 40;
            r.target = SENSOR_BITS'(clip(t, 0, (1 << SENSOR_BITS) - 1));
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted_commands.push_back(regulate_tick(s_tdata[SENSOR_BITS-1:0],
                    s_tdata[2*SENSOR_BITS-1:SENSOR_BITS], s_tuser));
            end
            if (!s_tvalid || s_tready) begin
                if (tick_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= S_TDATA_W'({tick_requests[0].target, tick_requests[0].sample});
                    s_tuser <= tick_requests[0].manual;
                    void'(tick_requests.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        arm_command_t exp_cmd;
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_commands.size() == 0) begin
                $error("result with no request waiting: tdata %h", m_tdata);
                mismatch_count++;
            end else begin
                exp_cmd = predicted_commands.pop_front();
                if (m_tdata[DRV_W-1:0] !== exp_cmd.drive) begin
                    $error("drive: expected %0d, actual %0d", exp_cmd.drive,
                           $signed(m_tdata[DRV_W-1:0]));
                    mismatch_count++;
                end
                if (m_tdata[DRV_W+ERR_W-1:DRV_W] !== exp_cmd.position_error) begin
                    $error("position_error: expected %0d, actual %0d",
                           exp_cmd.position_error, $signed(m_tdata[DRV_W+ERR_W-1:DRV_W]));
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("arm_position_pid_regulator_top_tb NOT OK");
            $finish;
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_POSITION_OFFSET:   cfg_offset = data[SENSOR_BITS-1:0];
            REG_GAIN_PROPORTIONAL: cfg_kp = data[GAIN_FRAC_BITS-1:0];
            REG_GAIN_INTEGRAL:     cfg_ki = data[GAIN_FRAC_BITS-1:0];
            REG_GAIN_DERIVATIVE:   cfg_kd = data[GAIN_FRAC_BITS-1:0];
            REG_INTEGRAL_DEADBAND: cfg_deadband = data[DEADBAND_W-1:0];
            REG_SCALE_MANUAL_DOWN: cfg_manual_down = data[SCALE_W-1:0];
            REG_SCALE_MANUAL_UP:   cfg_manual_up = data[SCALE_W-1:0];
            REG_SCALE_PRESET_UP:   cfg_preset_up = data[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_until_drained();
        while (tick_requests.size() != 0 || s_tvalid || predicted_commands.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_idle_mode(input idle_mode_t mode);
        send_idle_pct = (mode == IDLE_SENDER) ? 87 : ((mode == IDLE_BOTH) ? 22 : 0);
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 87 : ((mode == IDLE_BOTH) ? 22 : 0);
    endtask

    task automatic push_ticks(input int sample, input int target, input logic manual,
                              input int count);
        tick_req_t r;
        r.sample = SENSOR_BITS'(sample);
        r.target = SENSOR_BITS'(target);
        r.manual = manual;
        repeat (count) tick_requests.push_back(r);
    endtask

    // Upper data bits beyond each register's width are randomized to exercise masking.
    task automatic randomize_registers();
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_register(REG_POSITION_OFFSET, CFG_DATA_W'($urandom));
        write_register(REG_GAIN_PROPORTIONAL,
                       CFG_DATA_W'($urandom_range(24'hFFFFFF) >> $urandom_range(23)));
        write_register(REG_GAIN_INTEGRAL,
                       CFG_DATA_W'($urandom_range(24'hFFFFFF) >> $urandom_range(23)));
        write_register(REG_GAIN_DERIVATIVE,
                       CFG_DATA_W'($urandom_range(24'hFFFFFF) >> $urandom_range(23)));
        write_register(REG_INTEGRAL_DEADBAND,
                       {junk[CFG_DATA_W-1:8], 8'($urandom_range(255) >> $urandom_range(7))});
        write_register(REG_SCALE_MANUAL_DOWN, {junk[CFG_DATA_W-1:9],
                       9'(($urandom_range(4) == 0) ? $urandom_range(511) : $urandom_range(256))});
        write_register(REG_SCALE_MANUAL_UP, {junk[CFG_DATA_W-1:9],
                       9'(($urandom_range(4) == 0) ? $urandom_range(511) : $urandom_range(256))});
        write_register(REG_SCALE_PRESET_UP, {junk[CFG_DATA_W-1:9],
                       9'(($urandom_range(4) == 0) ? $urandom_range(511) : $urandom_range(256))});
    endtask

    initial begin
        idle_mode_t mode;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed ticks at the reset settings: zero error, both extremes in both modes,
        // errors inside and at the edge of the deadband, and alternating bit patterns.
        set_idle_mode(IDLE_NONE);
        push_ticks(0, 0, 1'b0, 1);
        push_ticks(0, 4095, 1'b0, 1);
        push_ticks(0, 4095, 1'b1, 1);
        push_ticks(4095, 0, 1'b1, 1);
        push_ticks(4095, 0, 1'b0, 2);
        push_ticks(100, 103, 1'b0, 1);
        push_ticks(100, 105, 1'b1, 1);
        push_ticks(2000, 1996, 1'b0, 1);
        push_ticks(2000, 1995, 1'b1, 1);
        push_ticks(4095, 4095, 1'b1, 1);
        push_ticks(12'hAAA, 12'h555, 1'b1, 1);
        push_ticks(12'h555, 12'hAAA, 1'b0, 1);
        push_ticks(2048, 2047, 1'b0, 1);
        push_ticks(1024, 1100, 1'b1, 1);
        push_ticks(1100, 1024, 1'b1, 1);
        push_ticks(3000, 2200, 1'b0, 1);
        wait_until_drained();

        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 1) begin
                write_register(REG_POSITION_OFFSET, '1);
                write_register(REG_GAIN_PROPORTIONAL, '1);
                write_register(REG_GAIN_INTEGRAL, '1);
                write_register(REG_GAIN_DERIVATIVE, '1);
                write_register(REG_INTEGRAL_DEADBAND, '1);
                write_register(REG_SCALE_MANUAL_DOWN, '1);
                write_register(REG_SCALE_MANUAL_UP, '1);
                write_register(REG_SCALE_PRESET_UP, '1);
                write_register(CFG_IDX_W'($urandom_range(REG_COUNT, REG_INDEX_MAX)),
                               CFG_DATA_W'($urandom));
            end else if (phase == 2) begin
                write_register(REG_POSITION_OFFSET, '0);
                write_register(REG_GAIN_PROPORTIONAL, '0);
                write_register(REG_GAIN_INTEGRAL, '0);
                write_register(REG_GAIN_DERIVATIVE, '0);
                write_register(REG_INTEGRAL_DEADBAND, '0);
                write_register(REG_SCALE_MANUAL_DOWN, '0);
                write_register(REG_SCALE_MANUAL_UP, '0);
                write_register(REG_SCALE_PRESET_UP, '0);
            end else if (phase > 2) begin
                randomize_registers();
                write_register(CFG_IDX_W'($urandom_range(REG_COUNT, REG_INDEX_MAX)),
                               CFG_DATA_W'($urandom));
            end
            mode = idle_mode_t'(phase % 4);
            set_idle_mode(mode);
            repeat (PHASE_TICKS) tick_requests.push_back(random_request());
            wait_until_drained();
        end

        // Integral run: with only the integral gain set, the drive follows the accumulated
        // error upward and then, after the integral is cleared, downward.
        set_idle_mode(IDLE_NONE);
        write_register(REG_POSITION_OFFSET, CFG_DATA_W'(4095));
        write_register(REG_GAIN_PROPORTIONAL, '0);
        write_register(REG_GAIN_INTEGRAL, CFG_DATA_W'(16384));
        write_register(REG_GAIN_DERIVATIVE, '0);
        write_register(REG_INTEGRAL_DEADBAND, CFG_DATA_W'(1));
        write_register(REG_SCALE_PRESET_UP, CFG_DATA_W'(256));
        push_ticks(4095, 0, 1'b0, 1);
        push_ticks(0, 4095, 1'b0, 24);
        wait_until_drained();
        write_register(REG_POSITION_OFFSET, '0);
        push_ticks(0, 0, 1'b0, 1);
        push_ticks(4095, 0, 1'b0, 24);
        wait_until_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("arm_position_pid_regulator_top_tb OK");
        end else begin
            $display("arm_position_pid_regulator_top_tb NOT OK");
        end
        $finish;
    end

endmodule
